// ----- rtl/slpb_pkg.sv -----
// ----------------------------------------------------------------------------
// slpb_pkg
// Shared types and constants for the status LED priority blinker: status
// codes, register indexes, reset values and timing constants.
// ----------------------------------------------------------------------------
package slpb_pkg;

  typedef enum logic [3:0] {
    ST_NONE      = 4'd0,
    ST_BOOT      = 4'd1,
    ST_ERROR     = 4'd2,
    ST_WARNING   = 4'd3,
    ST_OTA_SOLID = 4'd4,
    ST_OTA_BLINK = 4'd5,
    ST_API       = 4'd6,
    ST_WIFI      = 4'd7,
    ST_OK        = 4'd8,
    ST_USER      = 4'd9
  } status_e;

  typedef enum logic [3:0] {
    REG_ERROR_COLOR   = 4'd0,
    REG_WARNING_COLOR = 4'd1,
    REG_OK_COLOR      = 4'd2,
    REG_BOOT_COLOR    = 4'd3,
    REG_WIFI_COLOR    = 4'd4,
    REG_API_COLOR     = 4'd5,
    REG_OTA_COLOR     = 4'd6,
    REG_CONTROL_BITS  = 4'd7
  } reg_index_e;

  localparam int unsigned ColorW  = 24;
  localparam int unsigned CtrlW   = 11;
  localparam int unsigned PhaseW  = 16;
  localparam int unsigned OtaPhW  = 10;

  localparam logic [ColorW-1:0] ErrorColorRst   = 24'hFF0000;
  localparam logic [ColorW-1:0] WarningColorRst = 24'hFFA500;
  localparam logic [ColorW-1:0] OkColorRst      = 24'h00FF00;
  localparam logic [ColorW-1:0] BootColorRst    = 24'hFFFF00;
  localparam logic [ColorW-1:0] WifiColorRst    = 24'hFFFFFF;
  localparam logic [ColorW-1:0] ApiColorRst     = 24'h00FF00;
  localparam logic [ColorW-1:0] OtaColorRst     = 24'h0000FF;
  localparam logic [CtrlW-1:0]  ControlRst      = 11'd1280;

  localparam int unsigned CtrlUserBit = 9;
  localparam int unsigned CtrlOkBit   = 10;

  localparam logic [31:0] OtaSolidMs  = 32'd500;
  localparam logic [31:0] BootMs      = 32'd10000;
  localparam logic [31:0] UserIdleMs  = 32'd30000;
  localparam logic [OtaPhW-1:0] OtaPeriodMs = 10'd1000;
  localparam logic [OtaPhW-1:0] OtaOnMs     = 10'd500;

endpackage

// ----- rtl/slpb_scale.sv -----
// ----------------------------------------------------------------------------
// slpb_scale
// Brightness scaling of one packed RGB color: each channel becomes
// (c * b) >> 8 with the brightness saturated to 256.
// ----------------------------------------------------------------------------
module slpb_scale (
  input  logic [slpb_pkg::ColorW-1:0] color_i,
  input  logic [8:0]                  bright_i,
  output logic [7:0]                  red_o,
  output logic [7:0]                  green_o,
  output logic [7:0]                  blue_o
);

  logic [8:0]  bright;
  logic [15:0] prod_r;
  logic [15:0] prod_g;
  logic [15:0] prod_b;

  assign bright = (bright_i > 9'd256) ? 9'd256 : bright_i;

  assign prod_r = {8'd0, color_i[23:16]} * {7'd0, bright};
  assign prod_g = {8'd0, color_i[15:8]}  * {7'd0, bright};
  assign prod_b = {8'd0, color_i[7:0]}   * {7'd0, bright};

  assign red_o   = prod_r[15:8];
  assign green_o = prod_g[15:8];
  assign blue_o  = prod_b[15:8];

endmodule

// ----- rtl/status_led_priority_blinker.sv -----
// ----------------------------------------------------------------------------
// status_led_priority_blinker
// Picks an LED status by fixed priority on every millisecond tick and drives
// brightness-scaled RGB levels; blinking statuses write levels on edges only.
//
//   channel | handshake                 | payload
//   --------+---------------------------+---------------------------------
//   in      | in_valid_i / in_stall_o   | mode, status flags
//   out     | out_valid_o / out_stall_i | status code, levels, write, apply
//   cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// one transaction per cycle unless in_stall_o is high; a result appears in the cycle after its input
// input stalls while a result waits under out_stall_i; a leaving result
// frees the result register for a new input in the same cycle
// blink phases run as counters beside the millisecond count, no divider
// reset puts the block in boot state with all counters at zero
// ----------------------------------------------------------------------------
module status_led_priority_blinker #(
  parameter int unsigned ERROR_PERIOD_MS   = 250,
  parameter int unsigned WARNING_PERIOD_MS = 1000
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        mode_i,
  input  logic        error_flag_i,
  input  logic        warning_flag_i,
  input  logic        ota_active_i,
  input  logic        ota_mark_i,
  input  logic        wifi_up_i,
  input  logic        api_up_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  status_code_o,
  output logic [7:0]  red_level_o,
  output logic [7:0]  green_level_o,
  output logic [7:0]  blue_level_o,
  output logic        level_write_o,
  output logic        user_apply_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [3:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  localparam int unsigned PW = slpb_pkg::PhaseW;
  localparam logic [PW-1:0] ErrPeriod = PW'(ERROR_PERIOD_MS);
  localparam logic [PW-1:0] ErrOn     = PW'((ERROR_PERIOD_MS * 3) / 4);
  localparam logic [PW-1:0] WrnPeriod = PW'(WARNING_PERIOD_MS);
  localparam logic [PW-1:0] WrnOn     = PW'(WARNING_PERIOD_MS / 4);

  // configuration
  logic [23:0] error_color_q, warning_color_q, ok_color_q, boot_color_q;
  logic [23:0] wifi_color_q, api_color_q, ota_color_q;
  logic [slpb_pkg::CtrlW-1:0] control_q;
  logic cfg_we;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_color_q   <= slpb_pkg::ErrorColorRst;
      warning_color_q <= slpb_pkg::WarningColorRst;
      ok_color_q      <= slpb_pkg::OkColorRst;
      boot_color_q    <= slpb_pkg::BootColorRst;
      wifi_color_q    <= slpb_pkg::WifiColorRst;
      api_color_q     <= slpb_pkg::ApiColorRst;
      ota_color_q     <= slpb_pkg::OtaColorRst;
      control_q       <= slpb_pkg::ControlRst;
    end else if (cfg_we) begin
      case (cfg_index_i)
        slpb_pkg::REG_ERROR_COLOR:   error_color_q   <= cfg_data_i;
        slpb_pkg::REG_WARNING_COLOR: warning_color_q <= cfg_data_i;
        slpb_pkg::REG_OK_COLOR:      ok_color_q      <= cfg_data_i;
        slpb_pkg::REG_BOOT_COLOR:    boot_color_q    <= cfg_data_i;
        slpb_pkg::REG_WIFI_COLOR:    wifi_color_q    <= cfg_data_i;
        slpb_pkg::REG_API_COLOR:     api_color_q     <= cfg_data_i;
        slpb_pkg::REG_OTA_COLOR:     ota_color_q     <= cfg_data_i;
        slpb_pkg::REG_CONTROL_BITS:  control_q       <= cfg_data_i[slpb_pkg::CtrlW-1:0];
        default: ;
      endcase
    end
  end

  // handshake
  logic accept;
  logic out_valid_q, out_valid_d;

  assign in_stall_o  = out_valid_q && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  // state
  logic [31:0] ms_q, ms_d;
  logic [31:0] change_q, change_d;
  logic [31:0] mark_q, mark_d;
  logic [PW-1:0] err_ph_q, err_ph_d, wrn_ph_q, wrn_ph_d;
  logic [slpb_pkg::OtaPhW-1:0] ota_ph_q, ota_ph_d;
  slpb_pkg::status_e prev_q, prev_d, shown_q, shown_d, st;
  logic lit_q, lit_d, user_q, user_d, first_q, first_d;

  logic [31:0] mark_now;
  logic        changed;
  logic        lit_base;
  logic        drive;
  logic [23:0] drive_color;
  logic        apply;
  logic        wrap;
  logic [7:0]  red, green, blue;

  // status pick and level selection
  always_comb begin
    ms_d        = ms_q;
    change_d    = change_q;
    mark_d      = mark_q;
    prev_d      = prev_q;
    shown_d     = shown_q;
    lit_d       = lit_q;
    user_d      = user_q;
    first_d     = first_q;
    err_ph_d    = err_ph_q;
    wrn_ph_d    = wrn_ph_q;
    ota_ph_d    = ota_ph_q;
    drive       = 1'b0;
    drive_color = '0;
    apply       = 1'b0;
    changed     = 1'b0;
    lit_base    = lit_q;
    st          = slpb_pkg::ST_NONE;
    wrap        = (ms_q == 32'hFFFF_FFFF);
    mark_now    = ota_mark_i ? ms_q : mark_q;

    if (control_q[slpb_pkg::CtrlUserBit]) begin
      st = slpb_pkg::ST_USER;
    end else if (user_q && prev_q == slpb_pkg::ST_OK &&
                 (ms_q - change_q) >= slpb_pkg::UserIdleMs) begin
      st = slpb_pkg::ST_USER;
    end else if (ota_active_i) begin
      st = ((ms_q - mark_now) < slpb_pkg::OtaSolidMs) ? slpb_pkg::ST_OTA_SOLID
                                                       : slpb_pkg::ST_OTA_BLINK;
    end else if (error_flag_i) begin
      st = slpb_pkg::ST_ERROR;
    end else if (warning_flag_i) begin
      st = slpb_pkg::ST_WARNING;
    end else if (ms_q < slpb_pkg::BootMs) begin
      st = slpb_pkg::ST_BOOT;
    end else if (api_up_i) begin
      st = slpb_pkg::ST_API;
    end else if (wifi_up_i) begin
      st = slpb_pkg::ST_WIFI;
    end else if (control_q[slpb_pkg::CtrlOkBit]) begin
      st = slpb_pkg::ST_OK;
    end

    if (accept) begin
      if (mode_i) begin
        user_d = 1'b1;
        if (control_q[slpb_pkg::CtrlUserBit]) begin
          shown_d = slpb_pkg::ST_USER;
          apply   = 1'b1;
        end
      end else begin
        mark_d = mark_now;
        if (first_q) begin
          first_d  = 1'b0;
          change_d = ms_q;
        end else begin
          changed = (st != prev_q);
          if (changed) begin
            prev_d   = st;
            change_d = ms_q;
            lit_base = 1'b0;
          end
          shown_d = st;
          lit_d   = 1'b0;
          case (st)
            slpb_pkg::ST_ERROR: begin
              lit_d       = (err_ph_q < ErrOn);
              drive       = (lit_d != lit_base);
              drive_color = lit_d ? error_color_q : 24'd0;
            end
            slpb_pkg::ST_WARNING: begin
              lit_d       = (wrn_ph_q < WrnOn);
              drive       = (lit_d != lit_base);
              drive_color = lit_d ? warning_color_q : 24'd0;
            end
            slpb_pkg::ST_OTA_BLINK: begin
              lit_d       = (ota_ph_q < slpb_pkg::OtaOnMs);
              drive       = (lit_d != lit_base);
              drive_color = lit_d ? ota_color_q : 24'd0;
            end
            slpb_pkg::ST_BOOT: begin
              drive       = 1'b1;
              drive_color = boot_color_q;
            end
            slpb_pkg::ST_WIFI: begin
              drive       = 1'b1;
              drive_color = wifi_color_q;
            end
            slpb_pkg::ST_API: begin
              drive       = 1'b1;
              drive_color = api_color_q;
            end
            slpb_pkg::ST_OTA_SOLID: begin
              drive       = 1'b1;
              drive_color = ota_color_q;
            end
            slpb_pkg::ST_OK: begin
              drive       = 1'b1;
              drive_color = ok_color_q;
            end
            slpb_pkg::ST_USER: begin
              drive = 1'b0;
            end
            default: begin
              drive       = 1'b1;
              drive_color = 24'd0;
            end
          endcase
        end
        // millisecond count wraps at 2^32; blink phases wrap at their own periods and also restart when it wraps
        ms_d = ms_q + 32'd1;
        if (wrap || err_ph_q == ErrPeriod - PW'(1)) begin
          err_ph_d = '0;
        end else begin
          err_ph_d = err_ph_q + PW'(1);
        end
        if (wrap || wrn_ph_q == WrnPeriod - PW'(1)) begin
          wrn_ph_d = '0;
        end else begin
          wrn_ph_d = wrn_ph_q + PW'(1);
        end
        if (wrap || ota_ph_q == slpb_pkg::OtaPeriodMs - 10'd1) begin
          ota_ph_d = '0;
        end else begin
          ota_ph_d = ota_ph_q + 10'd1;
        end
      end
    end
  end

  slpb_scale u_scale (
    .color_i  (drive_color),
    .bright_i (control_q[8:0]),
    .red_o    (red),
    .green_o  (green),
    .blue_o   (blue)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ms_q        <= '0;
      change_q    <= '0;
      mark_q      <= '0;
      prev_q      <= slpb_pkg::ST_NONE;
      shown_q     <= slpb_pkg::ST_BOOT;
      lit_q       <= 1'b0;
      user_q      <= 1'b0;
      first_q     <= 1'b1;
      err_ph_q    <= '0;
      wrn_ph_q    <= '0;
      ota_ph_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ms_q        <= ms_d;
      change_q    <= change_d;
      mark_q      <= mark_d;
      prev_q      <= prev_d;
      shown_q     <= shown_d;
      lit_q       <= lit_d;
      user_q      <= user_d;
      first_q     <= first_d;
      err_ph_q    <= err_ph_d;
      wrn_ph_q    <= wrn_ph_d;
      ota_ph_q    <= ota_ph_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result register
  logic [3:0] status_q;
  logic [7:0] red_q, green_q, blue_q;
  logic       write_q, apply_q;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= shown_d;
      red_q    <= drive ? red : 8'd0;
      green_q  <= drive ? green : 8'd0;
      blue_q   <= drive ? blue : 8'd0;
      write_q  <= drive;
      apply_q  <= apply;
    end
  end

  assign status_code_o = status_q;
  assign red_level_o   = red_q;
  assign green_level_o = green_q;
  assign blue_level_o  = blue_q;
  assign level_write_o = write_q;
  assign user_apply_o  = apply_q;

endmodule
